// ===== src/hwde_pkg.sv =====
// ----------------------------------------------------------------------------
// Hashed word dictionary encoder package
// Shared constants, the hash multiplier and its per-byte product table.
// ----------------------------------------------------------------------------
package hwde_pkg;

	// Default configuration of the encoder.
	localparam int DEF_HASH_BITS    = 8;
	localparam int DEF_MAX_WORD_LEN = 7;

	// Word, key and group geometry.
	localparam int WORD_BITS   = 56;
	localparam int KEY_BITS    = 64;
	localparam int GROUP_BITS  = 6;
	localparam int MARK_LIMIT  = KEY_BITS / 8 - 2;

	localparam logic [KEY_BITS-1:0]   HASH_MULT   = 64'h9D6E_F916_9D6E_F917;
	localparam logic [7:0]            MARKER_BYTE = 8'hff;
	localparam logic [GROUP_BITS-1:0] GROUP_LAST  = 6'h3f;

	// Product of every byte value with the multiplier, modulo 2^64.
	typedef logic [KEY_BITS-1:0] mul_table_t [256];

	function automatic mul_table_t build_mul_table();
		mul_table_t tbl;
		for (int i = 0; i < 256; i++) begin
			tbl[i] = KEY_BITS'(KEY_BITS'(i) * HASH_MULT);
		end
		return tbl;
	endfunction

	localparam mul_table_t MUL_TABLE = build_mul_table();

endpackage

// ===== src/hwde_if.sv =====
// ----------------------------------------------------------------------------
// Hashed word dictionary encoder channels
// Valid/ready channels for input bytes and for encoded results.
// ----------------------------------------------------------------------------

// Input channel: one uncompressed byte per transfer.
interface hwde_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// Output channel: a code byte or a completed signature word.
interface hwde_code_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  code_byte;
	logic [63:0] signature_word;
	logic        last;

	modport source (output valid, output kind, output code_byte, output signature_word,
		output last, input ready);
	modport sink (input valid, input kind, input code_byte, input signature_word,
		input last, output ready);
endinterface

// ===== src/hashed_word_dictionary_encoder.sv =====
// A byte's code is registered in stage 1 and then in the result queue before it is offered.
// No new byte is taken while one is in stage 1 or the queue is full; the dictionary read, key
// compare and write-back of one byte must finish before the next byte extends the pending word
// and its running product. Reset: asynchronous; afterwards a clearing pass writes zero to all
// 2^HASH_BITS dictionary entries with the input held not ready.
// ----------------------------------------------------------------------------
// Hashed word dictionary encoder
// Grows a pending word byte by byte, hashes each extension incrementally and looks
// it up in a synchronous dictionary memory; misses and words at the maximum length emit codes and signature words.
// ----------------------------------------------------------------------------
module hashed_word_dictionary_encoder #(
	parameter int HASH_BITS    = hwde_pkg::DEF_HASH_BITS,
	parameter int MAX_WORD_LEN = hwde_pkg::DEF_MAX_WORD_LEN
) (
	input logic          clk,
	input logic          arst_n,
	hwde_byte_if.sink    byte_ch,
	hwde_code_if.source  code_ch
);

	localparam int DICT_DEPTH  = 1 << HASH_BITS;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam int WB          = hwde_pkg::WORD_BITS;
	localparam int KB          = hwde_pkg::KEY_BITS;
	localparam int GB          = hwde_pkg::GROUP_BITS;

	typedef enum logic [2:0] {
		STEP_START = 3'b001,
		STEP_LONG  = 3'b010,
		STEP_HASH  = 3'b100
	} step_t;

	// Clearing pass.
	logic                 clear_q;
	logic [HASH_BITS-1:0] clr_idx_q;

	// Encoder state.
	logic [WB-1:0]        word_q;
	logic [KB-1:0]        prod_q;
	logic [HASH_BITS-1:0] hash_q;
	logic [2:0]           len_q;
	logic [GB-1:0]        gp_q;
	logic [KB-1:0]        acc_q;

	// Stage 1 (lookup and update).
	logic                 busy_s1_q;
	step_t                step_s1;
	logic [7:0]           byte_s1;
	logic [WB-1:0]        ext_s1;
	logic [KB-1:0]        key_s1;
	logic [KB-1:0]        prod_s1;
	logic [KB-1:0]        entry_s1;
	logic [HASH_BITS-1:0] hash_s1;

	// Dictionary memory.
	logic [KB-1:0]        dict_mem [DICT_DEPTH];
	logic                 mem_we;
	logic [HASH_BITS-1:0] mem_addr;
	logic [KB-1:0]        mem_wdata;

	// Result queue, one record per emitting byte.
	logic [7:0]           q_code_q [QUEUE_DEPTH];
	logic                 q_done_q [QUEUE_DEPTH];
	logic [KB-1:0]        q_sig_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] q_count_q;
	logic                 phase_q;

	logic                 in_fire;
	logic                 out_fire;
	logic                 pop;
	logic [WB-1:0]        ext_word;
	logic [KB-1:0]        ext_prod;
	logic [HASH_BITS-1:0] ext_hash;
	logic [5:0]           mark_shift;
	logic [KB-1:0]        ext_key;
	step_t                step_in;

	logic                 hit;
	logic                 emit_en;
	logic [7:0]           emit_code;
	logic                 emit_flag;
	logic                 dict_wr;
	logic [WB-1:0]        word_d;
	logic [KB-1:0]        prod_d;
	logic [HASH_BITS-1:0] hash_d;
	logic [2:0]           len_d;
	logic [KB-1:0]        acc_set;
	logic                 group_done;

	assign in_fire  = byte_ch.valid && byte_ch.ready;
	assign out_fire = code_ch.valid && code_ch.ready;
	assign pop      = out_fire && code_ch.last;

	// After the clearing pass, a new byte is taken only when the lookup stage is free and the queue has room.
	assign byte_ch.ready = !clear_q && !busy_s1_q && (q_count_q < QCNT_BITS'(QUEUE_DEPTH));

	// Extension of the pending word; its product is the old product shifted by a byte
	// plus the product of the new byte.
	assign ext_word   = {word_q[WB-9:0], byte_ch.data_byte};
	assign ext_prod   = {prod_q[KB-9:0], 8'h00} + hwde_pkg::MUL_TABLE[byte_ch.data_byte];
	assign ext_hash   = ext_prod[KB-1 -: HASH_BITS];
	assign mark_shift = {len_q, 3'b000} + 6'd16;
	assign ext_key    = KB'(ext_word) |
		((len_q < 3'(hwde_pkg::MARK_LIMIT)) ? (KB'(hwde_pkg::MARKER_BYTE) << mark_shift) : '0);

	// Classify the byte by the pending length.
	always_comb begin
		if (len_q == 3'd0) begin
			step_in = STEP_START;
		end else if (len_q >= 3'(MAX_WORD_LEN)) begin
			step_in = STEP_LONG;
		end else begin
			step_in = STEP_HASH;
		end
	end

	// Stage 1 registers; the dictionary is read at the accept edge.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			step_s1  <= step_in;
			byte_s1  <= byte_ch.data_byte;
			ext_s1   <= ext_word;
			key_s1   <= ext_key;
			prod_s1  <= ext_prod;
			hash_s1  <= ext_hash;
			entry_s1 <= dict_mem[ext_hash];
		end
		if (mem_we) begin
			dict_mem[mem_addr] <= mem_wdata;
		end
	end

	assign hit = (entry_s1 == key_s1);

	// Stage 1 decision: grow the word on a hit; on a miss store the key and emit a code; a full word only emits.
	always_comb begin
		emit_en   = 1'b0;
		emit_code = 8'(hash_q);
		emit_flag = 1'b1;
		dict_wr   = 1'b0;
		word_d    = WB'(byte_s1);
		prod_d    = hwde_pkg::MUL_TABLE[byte_s1];
		hash_d    = hash_q;
		len_d     = 3'd1;
		case (step_s1)
			STEP_START: begin
			end
			STEP_LONG: begin
				emit_en = 1'b1;
			end
			STEP_HASH: begin
				hash_d = hash_s1;
				if (hit) begin
					word_d = ext_s1;
					prod_d = prod_s1;
					len_d  = len_q + 3'd1;
				end else begin
					dict_wr = 1'b1;
					emit_en = 1'b1;
					if (len_q == 3'd1) begin
						emit_code = word_q[7:0];
						emit_flag = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Dictionary write port: clearing pass or a stored key.
	assign mem_we    = clear_q || (busy_s1_q && dict_wr);
	assign mem_addr  = clear_q ? clr_idx_q : hash_s1;
	assign mem_wdata = clear_q ? '0 : key_s1;

	// Flag packing into the signature word.
	assign acc_set    = acc_q | (KB'(emit_flag) << gp_q);
	assign group_done = (gp_q == hwde_pkg::GROUP_LAST);

	// Control and encoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_idx_q <= '0;
			busy_s1_q <= 1'b0;
			word_q    <= '0;
			prod_q    <= '0;
			hash_q    <= '0;
			len_q     <= '0;
			gp_q      <= '0;
			acc_q     <= '0;
		end else begin
			if (clear_q) begin
				clr_idx_q <= clr_idx_q + HASH_BITS'(1);
				if (clr_idx_q == HASH_BITS'(DICT_DEPTH - 1)) begin
					clear_q <= 1'b0;
				end
			end
			busy_s1_q <= in_fire;
			if (busy_s1_q) begin
				word_q <= word_d;
				prod_q <= prod_d;
				hash_q <= hash_d;
				len_q  <= len_d;
				if (emit_en) begin
					if (group_done) begin
						acc_q <= '0;
						gp_q  <= '0;
					end else begin
						acc_q <= acc_set;
						gp_q  <= gp_q + GB'(1);
					end
				end
			end
		end
	end

	// Result queue payload.
	always_ff @(posedge clk) begin
		if (busy_s1_q && emit_en) begin
			q_code_q[wr_ptr_q] <= emit_code;
			q_done_q[wr_ptr_q] <= group_done;
			q_sig_q[wr_ptr_q]  <= acc_set;
		end
	end

	// Result queue pointers and the code/signature phase of the head record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			q_count_q <= '0;
			phase_q   <= 1'b0;
		end else begin
			if (busy_s1_q && emit_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			q_count_q <= q_count_q + QCNT_BITS'(busy_s1_q && emit_en) - QCNT_BITS'(pop);
			if (out_fire) begin
				phase_q <= !code_ch.last;
			end
		end
	end

	// Output word: the code first, then the signature when its group is full.
	assign code_ch.valid          = (q_count_q != '0);
	assign code_ch.kind           = phase_q;
	assign code_ch.code_byte      = phase_q ? 8'h00 : q_code_q[rd_ptr_q];
	assign code_ch.signature_word = phase_q ? q_sig_q[rd_ptr_q] : '0;
	assign code_ch.last           = phase_q || !q_done_q[rd_ptr_q];

	// The lookup stage holds a byte for exactly one cycle.
	a_s1_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1_q |=> !busy_s1_q)
		else $error("lookup stage occupied in two consecutive cycles");

	// The clearing pass never overlaps a byte in flight.
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !busy_s1_q)
		else $error("byte in flight during dictionary clearing");

	// The result queue never overflows.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// The pending word never exceeds its maximum length, and a finished byte leaves a word.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1_q |=> (len_q != 3'd0) && (len_q <= 3'(MAX_WORD_LEN)))
		else $error("pending length out of range");

endmodule
